>>> rtl/tw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tw_pkg;

    localparam int DUR_W   = 24;
    localparam int DELTA_W = 16;
    localparam int VAL_W   = 32;
    localparam int COL_W   = 32;
    localparam int CH_W    = 8;
    localparam int Q_W     = 16;          // fraction bits of progress
    localparam int T_W     = Q_W + 1;     // progress incl. the 1.0 code
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W  = 2;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [T_W-1:0] ONE_Q16  = T_W'(1) << Q_W;
    localparam logic [T_W-1:0] HALF_Q16 = T_W'(1) << (Q_W - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EASING_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_VALUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 3'd5;

    // easing codes
    localparam logic [MODE_W-1:0] EASE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] EASE_IN     = 2'd1;
    localparam logic [MODE_W-1:0] EASE_OUT    = 2'd2;
    localparam logic [MODE_W-1:0] EASE_IN_OUT = 2'd3;

    typedef struct packed {
        logic             start;
        logic [DUR_W-1:0] rem0;
        logic [DUR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> rtl/tw_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module tw_div import tw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(Q_W);

    logic [DUR_W-1:0] r_rem, n_rem;
    logic [DUR_W-1:0] r_dvs;
    logic [Q_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DUR_W:0] sh;
    logic [DUR_W:0] diff;
    logic           ge;

    always_comb begin
        sh    = {r_rem, 1'b0};
        ge    = sh >= {1'b0, r_dvs};
        diff  = sh - {1'b0, r_dvs};
        n_rem = ge ? diff[DUR_W-1:0] : sh[DUR_W-1:0];
        n_quo = {r_quo[Q_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(Q_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem0;
            r_dvs <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

>>> rtl/tw_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// shared signed multiplier, product registered
module tw_mul import tw_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic signed [MUL_A_W-1:0] i_a,
    input  wire logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0]      o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> rtl/eased_value_and_color_tween.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    direction  handshake           payload
// tick in    input      i_valid / o_ready   i_delta_units
// result     output     o_valid / i_ready   o_current_value, o_current_color, o_done_res
// config     input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// a tick runs from acceptance to its result and to the next o_ready through: update,
// path select, the divider (16 quotient bits and its done step), six multiplies
// on the shared multiplier (square, value lerp, four colour channels), one load
// elapsed at duration skips the divider, zero duration the multiplies too
// reset clears the sequencer, elapsed time, finished flag, output valid and config registers
// a result waiting on i_ready holds the sequencer in its load step; o_ready returns once loaded
module eased_value_and_color_tween import tw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tick requests
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DELTA_W-1:0]    i_delta_units,
    // results
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [VAL_W-1:0]    o_current_value,
    output logic [COL_W-1:0]           o_current_color,
    output logic                       o_done_res,
    // register writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD  = 4'd1;   // add delta, saturate
    localparam logic [3:0] S_CHK  = 4'd2;   // pick the progress path
    localparam logic [3:0] S_DIV  = 4'd3;   // wait for the divider
    localparam logic [3:0] S_SQR  = 4'd4;   // issue square for easing
    localparam logic [3:0] S_EASE = 4'd5;   // form eased progress
    localparam logic [3:0] S_VAL  = 4'd6;   // issue value lerp
    localparam logic [3:0] S_VALR = 4'd7;   // form value
    localparam logic [3:0] S_COL  = 4'd8;   // issue one colour channel
    localparam logic [3:0] S_COLR = 4'd9;   // form that channel
    localparam logic [3:0] S_DONE = 4'd10;  // load result register

    // configuration registers
    logic [MODE_W-1:0] r_mode;
    logic [DUR_W-1:0]  r_dur;
    logic [VAL_W-1:0]  r_start_value;
    logic [VAL_W-1:0]  r_end_value;
    logic [COL_W-1:0]  r_start_color;
    logic [COL_W-1:0]  r_end_color;

    // tween state
    logic [DUR_W-1:0]  r_elapsed, n_elapsed;
    logic              r_finished, n_finished;

    // sequencer and working registers
    logic [3:0]        r_state, n_state;
    logic [DELTA_W-1:0] r_delta;
    logic [T_W-1:0]    r_t, n_t;
    logic [T_W-1:0]    r_e, n_e;
    logic [VAL_W-1:0]  r_value, n_value;
    logic [COL_W-1:0]  r_color, n_color;
    logic [1:0]        r_ch, n_ch;

    // result register
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    logic [COL_W-1:0]  r_out_color, n_out_color;
    logic              r_out_done, n_out_done;

    // shared units
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic [DUR_W:0]    sum;
    logic [T_W-1:0]    u;
    logic              t_low;
    logic [T_W-1:0]    sq_x;
    logic [VAL_W:0]    val_diff;
    logic [CH_W-1:0]   ch_s, ch_n;
    logic [CH_W:0]     ch_diff;
    logic [27:0]       ch_total;
    logic              load_out;

    tw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // register writes; the user must write only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= '0;
            r_dur         <= '0;
            r_start_value <= '0;
            r_end_value   <= '0;
            r_start_color <= '0;
            r_end_color   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EASING_MODE: r_mode        <= i_cfg_data[MODE_W-1:0];
                REG_DURATION:    r_dur         <= i_cfg_data[DUR_W-1:0];
                REG_START_VALUE: r_start_value <= i_cfg_data[VAL_W-1:0];
                REG_END_VALUE:   r_end_value   <= i_cfg_data[VAL_W-1:0];
                REG_START_COLOR: r_start_color <= i_cfg_data[COL_W-1:0];
                REG_END_COLOR:   r_end_color   <= i_cfg_data[COL_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // easing operand and helpers
    always_comb begin
        u     = ONE_Q16 - r_t;
        t_low = r_t < HALF_Q16;
        unique case (r_mode)
            EASE_IN:     sq_x = r_t;
            EASE_OUT:    sq_x = u;
            EASE_IN_OUT: sq_x = t_low ? r_t : u;
            default:     sq_x = r_t;
        endcase
        val_diff = {r_end_value[VAL_W-1], r_end_value}
                 - {r_start_value[VAL_W-1], r_start_value};
        ch_s     = r_start_color[r_ch*CH_W +: CH_W];
        ch_n     = r_end_color[r_ch*CH_W +: CH_W];
        ch_diff  = {1'b0, ch_n} - {1'b0, ch_s};
        // s*65536 + (n-s)*e + half, channel sits in bits 23:16
        ch_total = mul_p[27:0] + {4'b0, ch_s, 16'h8000};
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQR: begin
                mul_a = {{(MUL_A_W-T_W){1'b0}}, sq_x};
                mul_b = {1'b0, sq_x};
            end
            S_VAL: begin
                mul_a = {val_diff[VAL_W], val_diff};
                mul_b = {1'b0, r_e};
            end
            S_COL: begin
                mul_a = {{(MUL_A_W-CH_W-1){ch_diff[CH_W]}}, ch_diff};
                mul_b = {1'b0, r_e};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_elapsed   = r_elapsed;
        n_finished  = r_finished;
        n_t         = r_t;
        n_e         = r_e;
        n_value     = r_value;
        n_color     = r_color;
        n_ch        = r_ch;
        n_out_valid = r_out_valid & ~i_ready;
        n_out_value = r_out_value;
        n_out_color = r_out_color;
        n_out_done  = r_out_done;
        load_out    = 1'b0;

        div_req.start   = 1'b0;
        div_req.rem0    = r_elapsed;
        div_req.divisor = r_dur;

        sum = {1'b0, r_elapsed} + {{(DUR_W+1-DELTA_W){1'b0}}, r_delta};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // finished ticks leave the state alone
                if (!r_finished) begin
                    if (sum >= {1'b0, r_dur}) begin
                        n_elapsed  = r_dur;
                        n_finished = 1'b1;
                    end else begin
                        n_elapsed = sum[DUR_W-1:0];
                    end
                end
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_dur == '0) begin
                    // zero duration jumps to the end
                    n_value = r_end_value;
                    n_color = r_end_color;
                    n_state = S_DONE;
                end else if (r_elapsed >= r_dur) begin
                    n_t     = ONE_Q16;
                    n_state = S_SQR;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_t     = {1'b0, div_rsp.quo};
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                n_state = S_EASE;
            end
            S_EASE: begin
                unique case (r_mode)
                    EASE_IN:     n_e = mul_p[32:16];
                    EASE_OUT:    n_e = ONE_Q16 - mul_p[32:16];
                    EASE_IN_OUT: n_e = t_low ? mul_p[31:15] : ONE_Q16 - mul_p[31:15];
                    default:     n_e = r_t;
                endcase
                n_state = S_VAL;
            end
            S_VAL: begin
                n_state = S_VALR;
            end
            S_VALR: begin
                // arithmetic shift floors towards minus infinity
                n_value = r_start_value + mul_p[47:16];
                n_ch    = 2'd0;
                n_state = S_COL;
            end
            S_COL: begin
                n_state = S_COLR;
            end
            S_COLR: begin
                n_color[r_ch*CH_W +: CH_W] = ch_total[23:16];
                n_ch = r_ch + 2'd1;
                if (r_ch == 2'd3) begin
                    // endpoints give the exact colours
                    if (r_elapsed >= r_dur) begin
                        n_color = r_end_color;
                    end else if (r_elapsed == '0) begin
                        n_color = r_start_color;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_COL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_value = r_value;
            n_out_color = r_color;
            n_out_done  = r_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
            r_ch        <= n_ch;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_delta <= i_delta_units;
        end
        r_t         <= n_t;
        r_e         <= n_e;
        r_value     <= n_value;
        r_color     <= n_color;
        r_out_value <= n_out_value;
        r_out_color <= n_out_color;
        r_out_done  <= n_out_done;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_current_value = r_out_value;
    assign o_current_color = r_out_color;
    assign o_done_res      = r_out_done;

endmodule

`default_nettype wire

>>> tb/eased_value_and_color_tween_tb.sv
`timescale 1ns / 1ps

module eased_value_and_color_tween_tb;
    import tw_pkg::*;

    // indexes past the last register, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [DUR_W-1:0] DUR_MAX = '1;
    localparam int PHASE_TICKS_MAX  = 40;    // longest run of ticks between rewrites
    localparam int RUNNING_TICKS    = 620;   // ticks sent before the tween is finished
    localparam int TOTAL_TICKS      = 1010;
    localparam int STALL_LIMIT      = 2000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_CYCLES     = 60;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [COL_W-1:0]        color;
        logic                    done;
    } t_frame;

    // shadow of the tween registers and timing state, with the frames still to come
    class tween_scoreboard;
        logic [MODE_W-1:0]       mode;
        logic [DUR_W-1:0]        duration;
        logic signed [VAL_W-1:0] value_from;
        logic signed [VAL_W-1:0] value_to;
        logic [COL_W-1:0]        color_from;
        logic [COL_W-1:0]        color_to;
        logic [DUR_W-1:0]        elapsed;
        bit                      finished;
        t_frame                  frames_due[$];
        int                      errors;

        function new();
            mode       = EASE_LINEAR;
            duration   = '0;
            value_from = '0;
            value_to   = '0;
            color_from = '0;
            color_to   = '0;
            elapsed    = '0;
            finished   = 0;
            errors     = 0;
        endfunction

        function void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_EASING_MODE: mode       = data[MODE_W-1:0];
                REG_DURATION:    duration   = data[DUR_W-1:0];
                REG_START_VALUE: value_from = data;
                REG_END_VALUE:   value_to   = data;
                REG_START_COLOR: color_from = data;
                REG_END_COLOR:   color_to   = data;
                default: ;
            endcase
        endfunction

        // elapsed / duration in q1.16, clamped at one
        function logic [T_W-1:0] tween_progress();
            longint unsigned q;
            if (duration == 0)
                return ONE_Q16;
            q = (longint'(elapsed) << Q_W) / longint'(duration);
            if (q > ONE_Q16)
                q = ONE_Q16;
            return T_W'(q);
        endfunction

        function logic [T_W-1:0] eased_progress(input logic [T_W-1:0] t);
            longint unsigned tt;
            longint unsigned u;
            tt = t;
            u  = ONE_Q16 - t;
            case (mode)
                EASE_IN:  return T_W'((tt * tt) >> Q_W);
                EASE_OUT: return ONE_Q16 - T_W'((u * u) >> Q_W);
                EASE_IN_OUT: begin
                    if (t < HALF_Q16)
                        return T_W'((2 * tt * tt) >> Q_W);
                    return ONE_Q16 - T_W'((2 * u * u) >> Q_W);
                end
                default: return t;
            endcase
        endfunction

        // step is floored, so the value never leaves the start..end span
        function logic [VAL_W-1:0] value_at(input logic [T_W-1:0] e);
            longint s;
            longint n;
            longint p;
            s = value_from;
            n = value_to;
            p = (n - s) * longint'(e);
            return VAL_W'(s + (p >>> Q_W));
        endfunction

        // per channel lerp, rounded half up
        function logic [COL_W-1:0] color_at(input logic [T_W-1:0] e);
            longint s;
            longint n;
            longint total;
            logic [COL_W-1:0] mix;
            int k;
            mix = '0;
            for (k = 0; k < COL_W / CH_W; k++) begin
                s     = color_from[k*CH_W +: CH_W];
                n     = color_to[k*CH_W +: CH_W];
                total = s * 65536 + (n - s) * longint'(e) + 32768;
                mix[k*CH_W +: CH_W] = total[Q_W +: CH_W];
            end
            return mix;
        endfunction

        function void take_tick(input logic [DELTA_W-1:0] delta);
            logic [DUR_W:0]   sum;
            logic [T_W-1:0]   e;
            t_frame           f;
            if (!finished) begin
                sum = elapsed + delta;
                if (sum >= duration) begin
                    sum      = duration;
                    finished = 1;
                end
                elapsed = sum[DUR_W-1:0];
            end
            f.done = finished;
            if (duration == 0) begin
                f.value = value_to;
                f.color = color_to;
            end else begin
                e       = eased_progress(tween_progress());
                f.value = value_at(e);
                if (elapsed >= duration)
                    f.color = color_to;
                else if (elapsed == 0)
                    f.color = color_from;
                else
                    f.color = color_at(e);
            end
            frames_due.push_back(f);
        endfunction

        function void check_frame(input logic signed [VAL_W-1:0] value,
                                  input logic [COL_W-1:0] color,
                                  input logic done);
            t_frame want;
            if (frames_due.size() == 0) begin
                $error("result with no tick pending: value %h colour %h done %b",
                       value, color, done);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (value !== want.value) begin
                $error("current_value: expected %h, got %h", want.value, value);
                errors++;
            end
            if (color !== want.color) begin
                $error("current_color: expected %h, got %h", want.color, color);
                errors++;
            end
            if (done !== want.done) begin
                $error("done_res: expected %b, got %b", want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [DELTA_W-1:0]      i_delta_units;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [VAL_W-1:0] o_current_value;
    logic [COL_W-1:0]        o_current_color;
    logic                    o_done_res;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    tween_scoreboard sb;
    int              ticks_sent = 0;
    bit              quiet = 0;      // no idling on either side for this phase
    int              idle_cycles = 0;

    eased_value_and_color_tween DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_delta_units   (i_delta_units),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_current_value (o_current_value),
        .o_current_color (o_current_color),
        .o_done_res      (o_done_res),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // extremes favoured, otherwise any 32-bit value
    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // each channel drawn on its own, dark and saturated channels favoured
    function automatic logic [COL_W-1:0] rand_color();
        logic [COL_W-1:0] c;
        int k;
        c = $urandom;
        for (k = 0; k < COL_W / CH_W; k++) begin
            case ($urandom_range(0, 3))
                0: c[k*CH_W +: CH_W] = '0;
                1: c[k*CH_W +: CH_W] = '1;
                default: ;
            endcase
        end
        return c;
    endfunction

    // mostly short steps so that elapsed time lasts, with now and then a full-range one
    function automatic logic [DELTA_W-1:0] rand_delta();
        case ($urandom_range(0, 9))
            0:          return DELTA_W'($urandom_range(0, 65535));
            1:          return '0;
            2, 3, 4, 5: return DELTA_W'($urandom_range(0, 255));
            default:    return DELTA_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // let every frame drain; the block then sits idle and may be reconfigured
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.frames_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.apply_reg(idx, data);
    endtask

    // rewrite every register; upper data bits above a narrow register are junk
    task automatic set_tween(input logic [MODE_W-1:0] m, input logic [DUR_W-1:0] d,
                             input logic signed [VAL_W-1:0] v0,
                             input logic signed [VAL_W-1:0] v1,
                             input logic [COL_W-1:0] c0, input logic [COL_W-1:0] c1,
                             input bit spare);
        wait_idle();
        write_reg(REG_EASING_MODE, {30'($urandom), m});
        write_reg(REG_DURATION, {8'($urandom), d});
        write_reg(REG_START_VALUE, v0);
        write_reg(REG_END_VALUE, v1);
        write_reg(REG_START_COLOR, c0);
        write_reg(REG_END_COLOR, c1);
        if (spare) begin
            write_reg(REG_SPARE_6, $urandom);
            write_reg(REG_SPARE_7, $urandom);
        end else if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
        end
        i_cfg_we <= 1'b0;
        quiet = ($urandom_range(0, 3) == 0);
    endtask

    // one tick request; valid stays up after acceptance unless a gap follows
    task automatic send_tick(input logic [DELTA_W-1:0] d);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_delta_units <= d;
        do @(posedge i_clk); while (!o_ready);
        sb.take_tick(d);
        ticks_sent++;
    endtask

    // result side: random stall before each frame, then take it and check it
    initial begin
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_frame(o_current_value, o_current_color, o_done_res);
        end
    end

    initial begin
        logic [DUR_W-1:0] dur;
        longint           base;
        longint           span;
        int               n;
        int               route;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_delta_units = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: the tween must stay unfinished here, elapsed kept small ----

        // linear over the full signed span, black to white; first tick at elapsed zero
        set_tween(EASE_LINEAR, DUR_MAX, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'h0000_0000, 32'hffff_ffff, 1);
        send_tick('0);
        send_tick(16'hffff);
        send_tick(16'hffff);
        send_tick(16'h0001);

        // ease in, span reversed so the step is negative
        set_tween(EASE_IN, DUR_MAX, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'hffff_ffff, 32'h0000_0000, 0);
        send_tick('0);
        send_tick(16'h8000);

        // ease out towards minus one lsb: the floored step lands below zero
        set_tween(EASE_OUT, DUR_MAX, 32'sh0000_0000, -32'sd1, rand_color(), rand_color(), 0);
        send_tick(16'h0007);
        send_tick(16'hffff);

        // ease in-out just below and then exactly at the half-way point
        dur = DUR_W'(2 * (longint'(sb.elapsed) + 101));
        set_tween(EASE_IN_OUT, dur, rand_value(), rand_value(), rand_color(), rand_color(), 0);
        send_tick(16'd100);
        send_tick(16'd1);

        // start equals end
        set_tween(EASE_LINEAR, DUR_MAX, 32'sh1234_5678, 32'sh1234_5678,
                  32'h80ff_007f, 32'h80ff_007f, 0);
        send_tick(16'd3);

        // ---- random, still running: duration kept far enough ahead of elapsed ----
        while (ticks_sent < RUNNING_TICKS) begin
            n    = $urandom_range(8, PHASE_TICKS_MAX);
            base = longint'(sb.elapsed) + PHASE_TICKS_MAX * 65536;
            if (base >= DUR_MAX)
                dur = DUR_MAX;
            else
                dur = DUR_W'(base + ($urandom_range(0, DUR_MAX - base)
                                     >> $urandom_range(0, 20)));
            set_tween(MODE_W'($urandom_range(0, 3)), dur, rand_value(), rand_value(),
                      rand_color(), rand_color(), 0);
            repeat (n) send_tick(rand_delta());
        end

        // ---- the one finish of the run, reached by a randomly chosen route ----
        route = $urandom_range(0, 7);
        span  = longint'(sb.elapsed) + $urandom_range(1, 3000);
        dur   = (span > DUR_MAX) ? DUR_MAX : DUR_W'(span);
        case (route)
            0: begin
                // zero duration: the very next tick finishes, whatever its delta
                set_tween(MODE_W'($urandom_range(0, 3)), '0, rand_value(), rand_value(),
                          rand_color(), rand_color(), 0);
                send_tick($urandom_range(0, 1) ? '0 : rand_delta());
            end
            1, 2: begin
                // duration pulled to or below elapsed: progress clamps, next tick saturates
                dur = (sb.elapsed > 0) ? DUR_W'($urandom_range(1, sb.elapsed)) : '0;
                set_tween(MODE_W'($urandom_range(0, 3)), dur, rand_value(), rand_value(),
                          rand_color(), rand_color(), 0);
                send_tick(rand_delta());
            end
            3, 4, 5: begin
                // land exactly on the duration
                set_tween(MODE_W'($urandom_range(0, 3)), dur, rand_value(), rand_value(),
                          rand_color(), rand_color(), 0);
                while (!sb.finished) begin
                    span = longint'(sb.duration) - longint'(sb.elapsed);
                    send_tick((span <= 200) ? DELTA_W'(span)
                                            : DELTA_W'($urandom_range(0, 200)));
                end
            end
            default: begin
                // overshoot, elapsed saturates at the duration
                set_tween(MODE_W'($urandom_range(0, 3)), dur, rand_value(), rand_value(),
                          rand_color(), rand_color(), 0);
                while (!sb.finished)
                    send_tick(DELTA_W'($urandom_range(0, 400)));
            end
        endcase
        repeat ($urandom_range(1, 4)) send_tick(rand_delta());

        // ---- random, finished: elapsed is frozen, duration swept around it ----
        while (ticks_sent < TOTAL_TICKS) begin
            n    = $urandom_range(2, 12);
            base = sb.elapsed;
            case ($urandom_range(0, 9))
                0: dur = '0;
                1: dur = sb.elapsed;
                2: dur = (base > 0) ? DUR_W'($urandom_range(0, base - 1)) : '0;
                3: dur = (2 * base <= DUR_MAX) ? DUR_W'(2 * base) : DUR_MAX;
                4: dur = (base < DUR_MAX) ? DUR_W'(base + 1) : DUR_MAX;
                5: dur = DUR_MAX;
                default: begin
                    if (base < DUR_MAX)
                        dur = DUR_W'(base + 1 + ($urandom_range(0, DUR_MAX - base - 1)
                                                 >> $urandom_range(0, 23)));
                    else
                        dur = DUR_MAX;
                end
            endcase
            set_tween(MODE_W'($urandom_range(0, 3)), dur, rand_value(), rand_value(),
                      rand_color(), rand_color(), 0);
            repeat (n) send_tick(rand_delta());
        end

        // drain, then watch a while longer for stray frames
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.frames_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
